### sv/ast_pkg.sv
`timescale 1ns / 1ps

package ast_pkg;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 32;
   localparam int SECS_W   = 7;
   localparam int MS_BITS  = 10;

   localparam logic [MS_BITS-1:0] MS_PER_SEC = 10'd1000;

   // Test phases
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_Z_PREP = 4'd1;
   localparam logic [3:0] PH_Z_MEAS = 4'd2;
   localparam logic [3:0] PH_Z_RES  = 4'd3;
   localparam logic [3:0] PH_X_PREP = 4'd4;
   localparam logic [3:0] PH_X_MEAS = 4'd5;
   localparam logic [3:0] PH_X_RES  = 4'd6;
   localparam logic [3:0] PH_Y_PREP = 4'd7;
   localparam logic [3:0] PH_Y_MEAS = 4'd8;
   localparam logic [3:0] PH_Y_RES  = 4'd9;

   // Register indexes
   localparam logic [1:0] CSR_PREPARE_MS = 2'd0;
   localparam logic [1:0] CSR_MEASURE_MS = 2'd1;
   localparam logic [1:0] CSR_RANGE_LOW  = 2'd2;
   localparam logic [1:0] CSR_RANGE_HIGH = 2'd3;

   // Register reset values
   localparam logic [15:0]        PREPARE_MS_RST = 16'd3000;
   localparam logic [15:0]        MEASURE_MS_RST = 16'd5000;
   localparam logic signed [15:0] RANGE_LOW_RST  = -16'sd1050;
   localparam logic signed [15:0] RANGE_HIGH_RST = -16'sd950;

   typedef struct packed {
      logic [15:0]        prepare_ms;
      logic [15:0]        measure_ms;
      logic signed [15:0] range_low;
      logic signed [15:0] range_high;
   } ast_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ast_div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AVG_START,
      ST_AVG_DIV,
      ST_SEC_START,
      ST_SEC_DIV,
      ST_OUT
   } ast_state_type;

   function automatic logic is_prep(input logic [3:0] ph);
      return ph inside {PH_Z_PREP, PH_X_PREP, PH_Y_PREP};
   endfunction

   function automatic logic is_meas(input logic [3:0] ph);
      return ph inside {PH_Z_MEAS, PH_X_MEAS, PH_Y_MEAS};
   endfunction

   // Reading of the axis that belongs to a phase group
   function automatic logic signed [15:0] axis_of_phase(
      input logic [3:0]        ph,
      input logic signed [15:0] x,
      input logic signed [15:0] y,
      input logic signed [15:0] z
   );
      logic signed [15:0] a;
      case (ph) inside
         [PH_Z_PREP:PH_Z_RES]: a = z;
         [PH_X_PREP:PH_X_RES]: a = x;
         [PH_Y_PREP:PH_Y_RES]: a = y;
         default:              a = '0;
      endcase
      return a;
   endfunction

endpackage

### sv/ast_csr.sv
`timescale 1ns / 1ps

module ast_csr import ast_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output ast_cfg_type cfg
);

   ast_cfg_type cfg_ff;
   ast_cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PREPARE_MS: cfg_in.prepare_ms = csr_wdata;
            CSR_MEASURE_MS: cfg_in.measure_ms = csr_wdata;
            CSR_RANGE_LOW:  cfg_in.range_low  = csr_wdata;
            CSR_RANGE_HIGH: cfg_in.range_high = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prepare_ms <= PREPARE_MS_RST;
         cfg_ff.measure_ms <= MEASURE_MS_RST;
         cfg_ff.range_low  <= RANGE_LOW_RST;
         cfg_ff.range_high <= RANGE_HIGH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/ast_serdiv.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module ast_serdiv import ast_pkg::*; #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output ast_div_stat_type      stat
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff,  cnt_in;
   logic                  done_ff, done_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff,  rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff,  dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // One trial subtract per step
   always_comb begin
      trial   = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = (trial >= {1'b0, dvs_ff});
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = CNT_W'(DIVIDEND_W);
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient  = quot_ff;
   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;

endmodule

### sv/accel_axis_selftest_sequencer.sv
`timescale 1ns / 1ps
// Divider use: a request that ends a measure phase uses the shared bit-serial divider for the average; a
// non-faulted one that leaves the test in a prepare or measure phase uses it for the seconds left;
// all others (idle, result phase, faulted tick) skip it. The divider gives one quotient bit
// per cycle over 16+COUNT_BITS bits.
// Requests: one in flight; the next is accepted only once the previous result is loaded for output.
// Reset: synchronous; clears phase, timing, sum, count, average and pass, loads config defaults.
module accel_axis_selftest_sequencer import ast_pkg::*; #(
   parameter int COUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // time_ms[31:0], sample_x, sample_y, sample_z
   input  logic [1:0]  req_tuser,   // action, sample_fault
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // phase, pass_flag, average, seconds_left, shown_sample, pad
   output logic [0:0]  rsp_tuser,   // sensor_fault
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SUM_W = SAMPLE_W + COUNT_BITS;
   localparam int DVW   = (COUNT_BITS > MS_BITS) ? COUNT_BITS : MS_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   ast_cfg_type      cfg;
   ast_div_stat_type div_stat;
   ast_state_type    state_ff, state_in;

   logic [3:0]            phase_ff,  phase_in;
   logic [TIME_W-1:0]     start_ff,  start_in;
   logic [SUM_W-1:0]      sum_ff,    sum_in;
   logic [COUNT_BITS-1:0] count_ff,  count_in;
   logic signed [15:0]    avg_ff,    avg_in;
   logic                  pass_ff,   pass_in;
   logic [SECS_W-1:0]     secs_ff,   secs_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [47:0]           rsp_data_ff;
   logic                  rsp_fault_ff;

   // latched request
   logic                  action_ff, fault_ff;
   logic [TIME_W-1:0]     now_ff;
   logic signed [15:0]    sx_ff, sy_ff, sz_ff;

   logic                  div_start;
   logic [SUM_W-1:0]      div_dividend;
   logic [DVW-1:0]        div_divisor;
   logic [SUM_W-1:0]      div_quot;

   logic [TIME_W-1:0]     elapsed;
   logic                  prep_reached, meas_reached, sec_reached;
   logic [15:0]           sec_limit, sec_rem;
   logic signed [15:0]    axis, shown;
   logic [SUM_W-1:0]      sum_mag;
   logic [15:0]           quot16;
   logic signed [15:0]    avg_new;
   logic                  is_fault_tick;
   logic                  out_load;
   logic                  req_fire;

   ast_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ast_serdiv #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;

   // Request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_tuser[0];
         fault_ff  <= req_tuser[1];
         now_ff    <= req_tdata[31:0];
         sx_ff     <= req_tdata[47:32];
         sy_ff     <= req_tdata[63:48];
         sz_ff     <= req_tdata[79:64];
      end
   end

   // Phase timing and datapath helpers
   always_comb begin
      elapsed       = now_ff - start_ff;
      prep_reached  = (elapsed[31:16] != '0) || (elapsed[15:0] >= cfg.prepare_ms);
      meas_reached  = (elapsed[31:16] != '0) || (elapsed[15:0] >= cfg.measure_ms);
      sec_limit     = is_prep(phase_ff) ? cfg.prepare_ms : cfg.measure_ms;
      sec_reached   = is_prep(phase_ff) ? prep_reached : meas_reached;
      sec_rem       = sec_reached ? 16'd0 : (sec_limit - elapsed[15:0]);
      axis          = axis_of_phase(phase_ff, sx_ff, sy_ff, sz_ff);
      is_fault_tick = !action_ff && fault_ff;
      shown         = is_fault_tick ? 16'sd0 : axis;
      sum_mag       = sum_ff[SUM_W-1] ? (~sum_ff + SUM_W'(1)) : sum_ff;
      quot16        = div_quot[15:0];
      avg_new       = sum_ff[SUM_W-1] ? (~quot16 + 16'd1) : quot16;
   end

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      start_in     = start_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      pass_in      = pass_ff;
      secs_in      = secs_ff;
      div_start    = 1'b0;
      div_dividend = sum_mag;
      div_divisor  = DVW'(count_ff);
      out_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_SEC_START;
            if (action_ff) begin
               // select press: leave idle or a result phase
               case (phase_ff)
                  PH_IDLE:  begin phase_in = PH_Z_PREP; start_in = now_ff; end
                  PH_Z_RES: begin phase_in = PH_X_PREP; start_in = now_ff; end
                  PH_X_RES: begin phase_in = PH_Y_PREP; start_in = now_ff; end
                  PH_Y_RES: begin phase_in = PH_IDLE;   start_in = now_ff; end
                  default:  phase_in = phase_ff;
               endcase
            end else if (!fault_ff) begin
               if (is_prep(phase_ff)) begin
                  if (prep_reached) begin
                     phase_in = phase_ff + 4'd1;
                     start_in = now_ff;
                     sum_in   = '0;
                     count_in = '0;
                  end
               end else if (is_meas(phase_ff)) begin
                  // accumulate until the count saturates
                  if (count_ff != COUNT_MAX) begin
                     sum_in   = sum_ff + {{COUNT_BITS{axis[15]}}, axis};
                     count_in = count_ff + 1'b1;
                  end
                  if (meas_reached) state_in = ST_AVG_START;
               end
            end
         end
         ST_AVG_START: begin
            div_start    = 1'b1;
            div_dividend = sum_mag;
            div_divisor  = DVW'(count_ff);
            state_in     = ST_AVG_DIV;
         end
         ST_AVG_DIV: begin
            if (div_stat.done) begin
               avg_in   = avg_new;
               pass_in  = (avg_new >= cfg.range_low) && (avg_new <= cfg.range_high);
               phase_in = phase_ff + 4'd1;
               state_in = ST_SEC_START;
            end
         end
         ST_SEC_START: begin
            if (!is_fault_tick && (is_prep(phase_ff) || is_meas(phase_ff))) begin
               div_start    = 1'b1;
               div_dividend = SUM_W'(sec_rem);
               div_divisor  = DVW'(MS_PER_SEC);
               state_in     = ST_SEC_DIV;
            end else begin
               secs_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_SEC_DIV: begin
            if (div_stat.done) begin
               secs_in  = div_quot[SECS_W-1:0] + SECS_W'(1);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register valid
   always_comb begin
      if (out_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   // Control and test state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         start_ff     <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         avg_ff       <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         avg_ff       <= avg_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      secs_ff <= secs_in;
      if (out_load) begin
         rsp_data_ff  <= {4'b0000, shown, secs_ff, avg_ff, pass_ff, phase_ff};
         rsp_fault_ff <= is_fault_tick;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_fault_ff;

   // Checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_UPDATE))
      else $error("accepted request did not start an update");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_Y_RES)
      else $error("test phase out of range");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_AVG_DIV || state_ff == ST_SEC_DIV))
      else $error("divider finished outside a divide state");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before it was taken");

endmodule

### sim/tb_accel_axis_selftest_sequencer.sv
`timescale 1ns / 1ps

module tb_accel_axis_selftest_sequencer;
   import ast_pkg::*;

   localparam int COUNT_BITS  = 8;
   localparam int COUNT_SAT   = (1 << COUNT_BITS) - 1;
   localparam int DRAIN_WAIT  = 2 * (16 + COUNT_BITS) + 20;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 3000000;

   localparam logic ACT_TICK   = 1'b0;
   localparam logic ACT_SELECT = 1'b1;

   typedef struct {
      logic [3:0]         phase;
      logic               pass;
      logic signed [15:0] average;
      logic [6:0]         secs;
      logic signed [15:0] shown;
      logic               fault;
   } selftest_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;   // time_ms, sample_x, sample_y, sample_z
   logic [1:0]  req_tuser;   // action, sample_fault
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // phase, pass_flag, average, seconds_left, shown_sample, pad
   logic [0:0]  rsp_tuser;   // sensor_fault
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // predicted sequencer state and register copies
   logic [3:0]         sq_phase;
   logic [31:0]        sq_start;
   int                 sq_sum;
   int                 sq_count;
   logic signed [15:0] sq_avg;
   logic               sq_pass;
   logic [15:0]        cfg_prepare;
   logic [15:0]        cfg_measure;
   logic signed [15:0] cfg_low;
   logic signed [15:0] cfg_high;

   selftest_rsp_type expected_rsp[$];
   int            mismatches;
   int            cycle_count;
   logic [31:0]   now_ms;

   // sender burst control
   int   burst_left;
   logic sender_steady;

   // receiver stall control
   logic hold_request;
   int   hold_left;
   int   rx_mode;
   int   mode_left;
   logic [7:0] stall_mask;

   accel_axis_selftest_sequencer #(
      .COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Sequencer prediction
   // ------------------------------------------------------------------
   function automatic logic prepare_phase(input logic [3:0] ph);
      return ph == PH_Z_PREP || ph == PH_X_PREP || ph == PH_Y_PREP;
   endfunction

   function automatic logic measure_phase(input logic [3:0] ph);
      return ph == PH_Z_MEAS || ph == PH_X_MEAS || ph == PH_Y_MEAS;
   endfunction

   // idle and result phases only move on with a select press
   function automatic logic awaits_select(input logic [3:0] ph);
      return ph == PH_IDLE || ph == PH_Z_RES || ph == PH_X_RES || ph == PH_Y_RES;
   endfunction

   function automatic logic signed [15:0] axis_reading(input logic [3:0] ph,
         input logic signed [15:0] sx, input logic signed [15:0] sy,
         input logic signed [15:0] sz);
      if (ph >= PH_Z_PREP && ph <= PH_Z_RES) return sz;
      if (ph >= PH_X_PREP && ph <= PH_X_RES) return sx;
      if (ph >= PH_Y_PREP && ph <= PH_Y_RES) return sy;
      return '0;
   endfunction

   // remaining time clamps at zero, shown as whole seconds plus one
   function automatic logic [6:0] seconds_remaining(input logic [15:0] lim,
         input logic [31:0] elapsed);
      logic [31:0] rem;
      rem = (elapsed >= lim) ? 32'd0 : lim - elapsed;
      return 7'(rem / MS_PER_SEC + 1);
   endfunction

   function automatic selftest_rsp_type step_selftest(input logic act, input logic [31:0] now,
         input logic signed [15:0] sx, input logic signed [15:0] sy,
         input logic signed [15:0] sz, input logic flt);
      selftest_rsp_type r;
      logic [31:0]   elapsed;
      int            avg;
      r = '{default: '0};
      if (act == ACT_SELECT) begin
         case (sq_phase)
            PH_IDLE: begin
               sq_phase = PH_Z_PREP;
               sq_start = now;
            end
            PH_Z_RES: begin
               sq_phase = PH_X_PREP;
               sq_start = now;
            end
            PH_X_RES: begin
               sq_phase = PH_Y_PREP;
               sq_start = now;
            end
            PH_Y_RES: begin
               sq_phase = PH_IDLE;
               sq_start = now;
            end
            default: ;
         endcase
      end else if (flt) begin
         r.fault = 1'b1;
      end else begin
         elapsed = now - sq_start;
         if (prepare_phase(sq_phase)) begin
            if (elapsed >= cfg_prepare) begin
               sq_phase = sq_phase + 4'd1;
               sq_start = now;
               sq_sum   = 0;
               sq_count = 0;
            end
         end else if (measure_phase(sq_phase)) begin
            // count saturates; later samples are dropped from the sum
            if (sq_count < COUNT_SAT) begin
               sq_sum   = sq_sum + axis_reading(sq_phase, sx, sy, sz);
               sq_count = sq_count + 1;
            end
            if (elapsed >= cfg_measure) begin
               avg      = sq_sum / sq_count;
               sq_avg   = avg[15:0];
               sq_pass  = (sq_avg >= cfg_low) && (sq_avg <= cfg_high);
               sq_phase = sq_phase + 4'd1;
            end
         end
      end
      if (!r.fault) begin
         elapsed = now - sq_start;
         r.shown = axis_reading(sq_phase, sx, sy, sz);
         if (prepare_phase(sq_phase))
            r.secs = seconds_remaining(cfg_prepare, elapsed);
         else if (measure_phase(sq_phase))
            r.secs = seconds_remaining(cfg_measure, elapsed);
      end
      r.phase   = sq_phase;
      r.pass    = sq_pass;
      r.average = sq_avg;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Shared driving tasks
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic send_request(input logic act, input logic [31:0] now,
         input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] sz,
         input logic flt);
      int gap;
      req_tdata  <= {sz, sy, sx, now};
      req_tuser  <= {flt, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_rsp.push_back(step_selftest(act, now, sx, sy, sz, flt));
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0 && !sender_steady) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // drop valid and let every outstanding request finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PREPARE_MS: cfg_prepare = value;
         CSR_MEASURE_MS: cfg_measure = value;
         CSR_RANGE_LOW:  cfg_low     = value;
         CSR_RANGE_HIGH: cfg_high    = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_config(input int prep, input int meas, input int lo, input int hi);
      wait_idle();
      write_register(CSR_PREPARE_MS, prep[15:0]);
      write_register(CSR_MEASURE_MS, meas[15:0]);
      write_register(CSR_RANGE_LOW, lo[15:0]);
      write_register(CSR_RANGE_HIGH, hi[15:0]);
   endtask

   // mostly near the window center, sometimes anywhere
   function automatic logic [15:0] sample_near(input int center, input int spread);
      int v;
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      return v[15:0];
   endfunction

   // one request shaped by the predicted phase: mostly well-formed progress
   task automatic send_random_item(input int center, input int spread);
      int          pick;
      logic [31:0] lim;
      pick = $urandom_range(0, 99);
      if (awaits_select(sq_phase)) begin
         now_ms = now_ms + $urandom_range(0, 200);
         if (pick < 75)
            send_request(ACT_SELECT, now_ms, 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
         else
            send_request(ACT_TICK, now_ms, sample_near(center, spread),
                         sample_near(center, spread), sample_near(center, spread),
                         $urandom_range(0, 9) == 0);
      end else if (pick < 6) begin
         // select is ignored here
         send_request(ACT_SELECT, now_ms, 16'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom_range(0, 1)));
      end else if (pick < 14) begin
         now_ms = now_ms + $urandom_range(0, 300);
         send_request(ACT_TICK, now_ms, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
      end else begin
         lim = prepare_phase(sq_phase) ? cfg_prepare : cfg_measure;
         if (pick < 16)
            now_ms = $urandom;
         else
            now_ms = now_ms + $urandom_range(0, lim / 2 + 50);
         send_request(ACT_TICK, now_ms, sample_near(center, spread),
                      sample_near(center, spread), sample_near(center, spread), 1'b0);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // full Z, X, Y walk at reset settings, with ignored selects, faults and a time wrap
   task automatic test_directed();
      logic [31:0] t0;
      t0 = 32'h0001_0000;
      send_request(ACT_TICK,   t0,         16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
      send_request(ACT_TICK,   t0,         16'h1234, 16'h5678, 16'h9ABC, 1'b1);
      send_request(ACT_SELECT, t0 + 10,    16'h0001, 16'h0002, 16'h0003, 1'b1);
      send_request(ACT_SELECT, t0 + 20,    16'h0004, 16'h0005, 16'h0006, 1'b0);
      send_request(ACT_TICK,   t0 + 1010,  16'h0000, 16'h0000, -16'sd1000, 1'b0);
      send_request(ACT_TICK,   t0 + 2000,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_request(ACT_TICK,   t0 + 3010,  16'h0010, 16'h0020, -16'sd1000, 1'b0);
      send_request(ACT_SELECT, t0 + 4000,  16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_request(ACT_TICK,   t0 + 5010,  16'h0011, 16'h0021, -16'sd990, 1'b0);
      send_request(ACT_TICK,   t0 + 8010,  16'h0012, 16'h0022, -16'sd1003, 1'b0);
      send_request(ACT_TICK,   t0 + 9000,  16'h0013, 16'h0023, -16'sd1001, 1'b0);
      send_request(ACT_SELECT, t0 + 9000,  16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_request(ACT_TICK,   t0 + 12000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
      send_request(ACT_TICK,   t0 + 17000, 16'h7FFF, 16'h0001, 16'h0002, 1'b0);
      // Y phases straddle the 32-bit time wrap
      send_request(ACT_SELECT, 32'hFFFF_F000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_request(ACT_TICK,   32'hFFFF_FFFF, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
      send_request(ACT_TICK,   32'h0000_0400, 16'h0000, 16'h8000, 16'h0000, 1'b0);
      send_request(ACT_TICK,   32'h0000_0DC4, 16'h0000, 16'h8001, 16'h0000, 1'b0);
      send_request(ACT_TICK,   32'h0000_1788, 16'h0000, 16'h0001, 16'h0000, 1'b0);
      send_request(ACT_SELECT, 32'h0000_2000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      now_ms = 32'h0000_2000;
   endtask

   // more samples than the counter holds within one measure phase
   task automatic test_count_saturation();
      apply_config(100, 1, -300, 300);
      while (!measure_phase(sq_phase)) begin
         if (awaits_select(sq_phase)) begin
            send_request(ACT_SELECT, now_ms, 16'h0000, 16'h0000, 16'h0000, 1'b0);
         end else begin
            now_ms = now_ms + 70000;
            send_request(ACT_TICK, now_ms, sample_near(0, 400), sample_near(0, 400),
                         sample_near(0, 400), 1'b0);
         end
      end
      repeat (COUNT_SAT + 45)
         send_request(ACT_TICK, now_ms, sample_near(0, 400), sample_near(0, 400),
                      sample_near(0, 400), 1'b0);
      now_ms = now_ms + 1;
      send_request(ACT_TICK, now_ms, sample_near(0, 400), sample_near(0, 400),
                   sample_near(0, 400), 1'b0);
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      apply_config(300, 600, -100, 100);
      hold_request  = 1'b1;
      sender_steady = 1'b1;
      repeat (16) send_random_item(0, 150);
      sender_steady = 1'b0;
   endtask

   // random sequences under a series of settings, extremes first
   task automatic test_random_phases();
      int round;
      int prep;
      int meas;
      int lo;
      int hi;
      for (round = 0; round < 12; round++) begin
         case (round)
            0: begin
               prep = 0;     meas = 0;     lo = -32768; hi = 32767;
            end
            1: begin
               prep = 65535; meas = 65535; lo = 32767;  hi = -32768;
            end
            2: begin
               prep = 500;   meas = 1500;  lo = 200;    hi = -200;
            end
            default: begin
               prep = $urandom_range(0, 2000);
               meas = $urandom_range(0, 3000);
               lo   = int'($urandom_range(0, 3000)) - 2000;
               hi   = lo + int'($urandom_range(0, 600));
            end
         endcase
         apply_config(prep, meas, lo, hi);
         repeat (120) begin
            if (lo <= hi)
               send_random_item((lo + hi) / 2, (hi - lo) / 2 + 200);
            else
               send_random_item(0, 2000);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver stalls
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (mode_left == 0) begin
         rx_mode    = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 200);
         stall_mask = $urandom;
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ($urandom_range(0, 9) < 3);
            default: rsp_tready <= stall_mask[cycle_count % 8];
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Response check
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      selftest_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response with no request pending, phase %0d",
                                      rsp_tdata[3:0]));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata[3:0] !== want.phase)
               report_mismatch($sformatf("phase %0d, expected %0d",
                                         rsp_tdata[3:0], want.phase));
            if (rsp_tdata[4] !== want.pass)
               report_mismatch($sformatf("pass_flag %0b, expected %0b",
                                         rsp_tdata[4], want.pass));
            if (rsp_tdata[20:5] !== want.average)
               report_mismatch($sformatf("average %0d, expected %0d",
                                         $signed(rsp_tdata[20:5]), want.average));
            if (rsp_tdata[27:21] !== want.secs)
               report_mismatch($sformatf("seconds_left %0d, expected %0d",
                                         rsp_tdata[27:21], want.secs));
            if (rsp_tdata[43:28] !== want.shown)
               report_mismatch($sformatf("shown_sample %0d, expected %0d",
                                         $signed(rsp_tdata[43:28]), want.shown));
            if (rsp_tuser[0] !== want.fault)
               report_mismatch($sformatf("sensor_fault %0b, expected %0b",
                                         rsp_tuser[0], want.fault));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_accel_axis_selftest_sequencer failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_PREPARE_MS;
      csr_wdata     = '0;
      mismatches    = 0;
      cycle_count   = 0;
      now_ms        = '0;
      burst_left    = 1;
      sender_steady = 1'b0;
      hold_request  = 1'b0;
      hold_left     = 0;
      rx_mode       = 0;
      mode_left     = 0;
      stall_mask    = '1;
      sq_phase      = PH_IDLE;
      sq_start      = '0;
      sq_sum        = 0;
      sq_count      = 0;
      sq_avg        = '0;
      sq_pass       = 1'b0;
      cfg_prepare   = PREPARE_MS_RST;
      cfg_measure   = MEASURE_MS_RST;
      cfg_low       = RANGE_LOW_RST;
      cfg_high      = RANGE_HIGH_RST;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_count_saturation();
      test_backpressure();
      test_random_phases();
      wait_idle();

      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("tb_accel_axis_selftest_sequencer passed");
      else
         $display("tb_accel_axis_selftest_sequencer failed");
      $finish;
   end

endmodule

### accel_axis_selftest_sequencer.f
sv/ast_pkg.sv
sv/ast_csr.sv
sv/ast_serdiv.sv
sv/accel_axis_selftest_sequencer.sv
sim/tb_accel_axis_selftest_sequencer.sv
